[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared key width, operation and status codes, and the control word that the
// top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int KEY_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Requested operation.
    typedef enum logic
    {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } opcode_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0]
    {
        ST_DONE       = 2'd0,
        ST_FULL_REJ   = 2'd1,
        ST_EMPTY_REJ  = 2'd2
    } status_t;

    // Control word broadcast to all cells for one operation.
    typedef struct packed
    {
        logic             enq;
        logic             deq;
        logic [KEY_W-1:0] new_key;
    } cell_ctrl_t;

endpackage : spq_pkg

`default_nettype wire

[rtl/sorted_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue, top level
// Bounded queue of keys kept largest first in a chain of compare-and-shift
// cells.
// ----------------------------------------------------------------------------
// Usage:
// A command is transferred at a rising edge where start is high and busy is
// low; opcode selects insert (key_value) or removal of the head. busy is held
// low, so a command may be issued on every clock cycle.
// Each command yields exactly one result, shown for one cycle with done high,
// on the cycle after the command transfer, at one command per cycle. Every
// cell compares its key with the new key and shifts in parallel, so neither
// when the result appears nor the command rate depends on CAPACITY.
// status reports success, insert rejected when full or removal rejected when
// empty; served_key carries the removed head key, else zero. entry_count,
// now_empty and now_full give the fill state after the command; entry_count
// holds the low five bits of the count.
// Reset empties the queue at once and clears done. The receiver cannot stall:
// a result is gone after its cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_top
#(
    parameter int CAPACITY = 16
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire                           opcode,
    input  wire [spq_pkg::KEY_W-1:0]      key_value,
    output logic                          done,
    output logic [spq_pkg::STATUS_W-1:0]  status,
    output logic [spq_pkg::KEY_W-1:0]     served_key,
    output logic [spq_pkg::COUNT_W-1:0]   entry_count,
    output logic                          now_empty,
    output logic                          now_full
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          done_reg;
    spq_pkg::status_t              status_reg;
    spq_pkg::status_t              status_next;
    logic [spq_pkg::KEY_W-1:0]     served_reg;
    logic [spq_pkg::KEY_W-1:0]     served_next;

    logic                          accept;
    logic                          is_full;
    logic                          is_empty;
    spq_pkg::cell_ctrl_t           ctrl;

    logic [CAPACITY-1:0]           cell_lt;
    logic [CAPACITY-1:0]           cell_occ;
    logic [spq_pkg::KEY_W-1:0]     cell_key [CAPACITY];
    logic [CNT_W+spq_pkg::COUNT_W-1:0] count_wide;

    // Commands are taken on every cycle.
    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // Broadcast control for the cells; rejected commands leave them alone.
    always_comb
    begin
        ctrl.enq     = accept && (opcode == spq_pkg::OP_ENQUEUE) && !is_full;
        ctrl.deq     = accept && (opcode == spq_pkg::OP_DEQUEUE) && !is_empty;
        ctrl.new_key = key_value;
    end

    // Chain of cells; occupancy follows from the count.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign cell_occ[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            spq_cell u_cell
            (
                .clk       (clk),
                .ctrl      (ctrl),
                .occupied  (cell_occ[i]),
                .left_lt   (1'b0),
                .left_key  ('0),
                .right_key (cell_key[i+1]),
                .lt        (cell_lt[i]),
                .key       (cell_key[i])
            );
        end
        else if (i == CAPACITY - 1)
        begin : g_tail
            spq_cell u_cell
            (
                .clk       (clk),
                .ctrl      (ctrl),
                .occupied  (cell_occ[i]),
                .left_lt   (cell_lt[i-1]),
                .left_key  (cell_key[i-1]),
                .right_key (cell_key[i]),
                .lt        (cell_lt[i]),
                .key       (cell_key[i])
            );
        end
        else
        begin : g_mid
            spq_cell u_cell
            (
                .clk       (clk),
                .ctrl      (ctrl),
                .occupied  (cell_occ[i]),
                .left_lt   (cell_lt[i-1]),
                .left_key  (cell_key[i-1]),
                .right_key (cell_key[i+1]),
                .lt        (cell_lt[i]),
                .key       (cell_key[i])
            );
        end
    end

    // Result and count for the command being transferred.
    always_comb
    begin
        count_next  = count_reg;
        status_next = spq_pkg::ST_DONE;
        served_next = '0;
        if (opcode == spq_pkg::OP_ENQUEUE)
        begin
            if (is_full)
            begin
                status_next = spq_pkg::ST_FULL_REJ;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (is_empty)
            begin
                status_next = spq_pkg::ST_EMPTY_REJ;
            end
            else
            begin
                count_next  = count_reg - CNT_W'(1);
                served_next = cell_key[0];
            end
        end
    end

    // Count, strobe and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= spq_pkg::ST_DONE;
            served_reg <= '0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg  <= count_next;
                status_reg <= status_next;
                served_reg <= served_next;
            end
        end
    end

    // Result ports.
    assign count_wide  = {{spq_pkg::COUNT_W{1'b0}}, count_reg};
    assign done        = done_reg;
    assign status      = status_reg;
    assign served_key  = served_reg;
    assign entry_count = count_wide[spq_pkg::COUNT_W-1:0];
    assign now_empty   = is_empty;
    assign now_full    = is_full;

    // Every transferred command gives a result on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("command transfer gave no result");

    // The count never goes beyond the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    // The two front keys stay in descending order.
    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cell_key[0] >= cell_key[1]))
        else $error("head keys out of order");

    // A removal from an empty queue is rejected and leaves it empty.
    a_empty_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == spq_pkg::OP_DEQUEUE && is_empty)
            |=> (status_reg == spq_pkg::ST_EMPTY_REJ && is_empty))
        else $error("empty removal not rejected");

endmodule : sorted_priority_queue_top

`default_nettype wire

[rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one key of the descending chain. On an insert it keeps its key, takes
// the new key or takes its left neighbour's key; on a removal it takes its
// right neighbour's key.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
(
    input  wire                      clk,
    input  wire spq_pkg::cell_ctrl_t ctrl,
    input  wire                      occupied,
    input  wire                      left_lt,
    input  wire [spq_pkg::KEY_W-1:0] left_key,
    input  wire [spq_pkg::KEY_W-1:0] right_key,
    output logic                     lt,
    output logic [spq_pkg::KEY_W-1:0] key
);

    logic [spq_pkg::KEY_W-1:0] key_reg;
    logic [spq_pkg::KEY_W-1:0] key_next;

    // An empty slot counts as smaller than any new key, so the first such
    // cell in the chain is where the new key lands.
    assign lt  = !occupied || (key_reg < ctrl.new_key);
    assign key = key_reg;

    // Next key: shift back, take the new key, shift forward or hold.
    always_comb
    begin
        key_next = key_reg;
        if (ctrl.enq && lt)
        begin
            key_next = left_lt ? left_key : ctrl.new_key;
        end
        else if (ctrl.deq)
        begin
            key_next = right_key;
        end
    end

    // Key storage needs no reset: a slot is read only once it is occupied.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule : spq_cell

`default_nettype wire
